// ===== src/tlr_pkg.sv =====
// Package for the thick line rasterizer: item types and code constants.
`default_nettype none
package tlr_pkg;

	// action codes
	localparam logic ACT_START   = 1'b0;
	localparam logic ACT_ADVANCE = 1'b1;

	// configuration register indexes
	localparam logic REG_PEN_SIZE  = 1'b0;
	localparam logic REG_PEN_COLOR = 1'b1;

	localparam int CFG_DATA_BITS = 16;

	typedef struct packed {
		logic               action;
		logic signed [11:0] start_x;
		logic signed [11:0] start_y;
		logic signed [11:0] end_x;
		logic signed [11:0] end_y;
	} tlr_in_t;

	typedef struct packed {
		logic [7:0]  pixel_x;
		logic [7:0]  pixel_y;
		logic [15:0] pixel_color;
		logic        write_enable;
		logic        done_res;
	} tlr_out_t;

endpackage
`default_nettype wire

// ===== src/thick_line_rasterizer_top.sv =====
// Top level of the thick line rasterizer: Bresenham line stepping with a square pen.
`default_nettype none
// One item is taken every cycle while the output register is free or being
// emptied. A start item loads the endpoints and gives no result; each advance
// item gives one pixel result in the output register in the cycle after it is
// accepted. The footprint offsets and the Bresenham step update in the same
// cycle, so a line of N main points with pen size s takes N*(s/2*2+1)^2
// advance items, one per cycle while the output register takes them. Pixels
// off screen come out with write_enable low and zero coordinates; the last
// footprint pixel of the end point, or an advance while idle, raises done_res.
module thick_line_rasterizer_top
	import tlr_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 240,
	parameter int SCREEN_HEIGHT = 240,
	parameter int COORD_BITS    = 12
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic                     cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire tlr_in_t                  in_item,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output tlr_out_t                      out_item
);

	localparam int CB = COORD_BITS;
	localparam int SW = CB + 1;                 // spans
	localparam int EW = CB + 3;                 // step error
	localparam int CW = (CB + 1 > 13) ? CB + 1 : 13; // pixel position and screen compare

	localparam logic signed [CW-1:0] SCR_W = CW'(SCREEN_WIDTH);
	localparam logic signed [CW-1:0] SCR_H = CW'(SCREEN_HEIGHT);

	function automatic logic signed [CB-1:0] coord_of(input logic [11:0] v);
		logic [CB+11:0] z;
		z = {{CB{1'b0}}, v};
		return $signed(z[CB-1:0]);
	endfunction

	logic [3:0]  pen_size_q;
	logic [15:0] pen_color_q;

	logic signed [CB-1:0] cursor_x_q, cursor_y_q, target_x_q, target_y_q;
	logic signed [SW-1:0] span_x_q, neg_span_y_q;
	logic [1:0]           step_signs_q;
	logic signed [EW-1:0] step_error_q;
	logic signed [4:0]    pen_offset_x_q, pen_offset_y_q;
	logic                 busy_q;

	logic     out_valid_q;
	tlr_out_t out_item_q;

	logic accept;
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_size_q  <= 4'd1;
			pen_color_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PEN_SIZE:  pen_size_q  <= cfg_data[3:0];
				REG_PEN_COLOR: pen_color_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// start setup
	logic signed [CB-1:0] x0, y0, x1, y1;
	logic signed [SW-1:0] dx, dy, abs_dx, nabs_dy;
	logic signed [4:0]    h, neg_h;

	always_comb begin
		x0 = coord_of(in_item.start_x);
		y0 = coord_of(in_item.start_y);
		x1 = coord_of(in_item.end_x);
		y1 = coord_of(in_item.end_y);
		dx = {x1[CB-1], x1} - {x0[CB-1], x0};
		dy = {y1[CB-1], y1} - {y0[CB-1], y0};
		abs_dx  = dx[SW-1] ? -dx : dx;
		nabs_dy = dy[SW-1] ? dy : -dy;
		h     = {2'b00, pen_size_q[3:1]};
		neg_h = -h;
	end

	// advance: pixel position and next step
	logic signed [CW-1:0]  px, py;
	logic                  on_screen, at_end;
	logic signed [EW:0]    e2;
	logic                  step_x, step_y;
	logic signed [EW-1:0]  err_next;
	logic signed [CB-1:0]  cx_next, cy_next;

	always_comb begin
		px = {{(CW-CB){cursor_x_q[CB-1]}}, cursor_x_q}
			+ {{(CW-5){pen_offset_x_q[4]}}, pen_offset_x_q};
		py = {{(CW-CB){cursor_y_q[CB-1]}}, cursor_y_q}
			+ {{(CW-5){pen_offset_y_q[4]}}, pen_offset_y_q};
		on_screen = !px[CW-1] && (px < SCR_W) && !py[CW-1] && (py < SCR_H);
		at_end = (cursor_x_q == target_x_q) && (cursor_y_q == target_y_q);
		e2 = {step_error_q, 1'b0};
		step_x = e2 >= $signed({{(EW+1-SW){neg_span_y_q[SW-1]}}, neg_span_y_q});
		step_y = e2 <= $signed({{(EW+1-SW){span_x_q[SW-1]}}, span_x_q});
		err_next = step_error_q
			+ (step_x ? {{(EW-SW){neg_span_y_q[SW-1]}}, neg_span_y_q} : EW'(0))
			+ (step_y ? {{(EW-SW){span_x_q[SW-1]}}, span_x_q} : EW'(0));
		cx_next = cursor_x_q;
		cy_next = cursor_y_q;
		if (step_x) cx_next = step_signs_q[0] ? cursor_x_q - CB'(1) : cursor_x_q + CB'(1);
		if (step_y) cy_next = step_signs_q[1] ? cursor_y_q - CB'(1) : cursor_y_q + CB'(1);
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q     <= '0;
			cursor_y_q     <= '0;
			target_x_q     <= '0;
			target_y_q     <= '0;
			span_x_q       <= '0;
			neg_span_y_q   <= '0;
			step_signs_q   <= '0;
			step_error_q   <= '0;
			pen_offset_x_q <= '0;
			pen_offset_y_q <= '0;
			busy_q         <= 1'b0;
		end else if (accept) begin
			if (in_item.action == ACT_START) begin
				cursor_x_q     <= x0;
				cursor_y_q     <= y0;
				target_x_q     <= x1;
				target_y_q     <= y1;
				span_x_q       <= abs_dx;
				neg_span_y_q   <= nabs_dy;
				step_signs_q   <= {!(y0 < y1), !(x0 < x1)};
				step_error_q   <= {{(EW-SW){abs_dx[SW-1]}}, abs_dx}
					+ {{(EW-SW){nabs_dy[SW-1]}}, nabs_dy};
				pen_offset_x_q <= neg_h;
				pen_offset_y_q <= neg_h;
				busy_q         <= 1'b1;
			end else if (busy_q) begin
				if (pen_offset_y_q < h) begin
					pen_offset_y_q <= pen_offset_y_q + 5'sd1;
				end else if (pen_offset_x_q < h) begin
					pen_offset_x_q <= pen_offset_x_q + 5'sd1;
					pen_offset_y_q <= neg_h;
				end else if (at_end) begin
					busy_q <= 1'b0;
				end else begin
					step_error_q   <= err_next;
					cursor_x_q     <= cx_next;
					cursor_y_q     <= cy_next;
					pen_offset_x_q <= neg_h;
					pen_offset_y_q <= neg_h;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= (in_item.action == ACT_ADVANCE);
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_item.action == ACT_ADVANCE) begin
			out_item_q.pixel_color <= pen_color_q;
			if (!busy_q) begin
				out_item_q.pixel_x      <= '0;
				out_item_q.pixel_y      <= '0;
				out_item_q.write_enable <= 1'b0;
				out_item_q.done_res     <= 1'b1;
			end else begin
				out_item_q.pixel_x      <= on_screen ? px[7:0] : 8'd0;
				out_item_q.pixel_y      <= on_screen ? py[7:0] : 8'd0;
				out_item_q.write_enable <= on_screen;
				out_item_q.done_res     <= !(pen_offset_y_q < h) && !(pen_offset_x_q < h)
					&& at_end;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
`default_nettype wire
